// ===== src/sp_stack_pkg.sv =====
// ============================================================================
// sp_stack_pkg: shared definitions for the shared-pool multi-stack core
// Pool and stack sizes, field widths, codes and the lowest-set-bit encoder.
// ============================================================================
`default_nettype none

package sp_stack_pkg;

    localparam int POOL_SLOTS  = 32;
    localparam int STACK_COUNT = 3;

    localparam int IDX_W   = $clog2(POOL_SLOTS);
    localparam int LINK_W  = $clog2(POOL_SLOTS + 1);
    localparam int STK_W   = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int SID_W   = 2;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 1;
    localparam int USER_IN_W  = CMD_W + SID_W;
    localparam int STATUS_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LINK_W-1:0] NULL_CODE = LINK_W'(POOL_SLOTS);

    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_PUSH   = 2'd1,
        KIND_POP    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [STK_W-1:0]          stk;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } enc_t;

    function automatic enc_t lowest_set(input logic [POOL_SLOTS-1:0] vec);
        enc_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/sp_ram.sv =====
// ============================================================================
// sp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module sp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/sp_front.sv =====
// ============================================================================
// sp_front: input beat acceptance, classification and work queue
// Decodes each beat into push, pop or ignore and holds it in a short queue.
// ============================================================================
`default_nettype none

module sp_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic        [sp_stack_pkg::VALUE_W-1:0]   s_tdata,
    input  wire logic        [sp_stack_pkg::USER_IN_W-1:0] s_tuser,
    output logic                                      q_valid,
    output sp_stack_pkg::item_t                       q_item,
    input  wire logic                                 q_pop
);

    localparam int PTR_W = $clog2(sp_stack_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sp_stack_pkg::QUEUE_DEPTH + 1);

    sp_stack_pkg::item_t             slot_reg [sp_stack_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    sp_stack_pkg::item_t             in_item;
    logic [sp_stack_pkg::CMD_W-1:0]  cmd;
    logic [sp_stack_pkg::SID_W-1:0]  sid;
    logic                            push_beat;
    logic                            pop_beat;

    assign cmd = s_tuser[sp_stack_pkg::CMD_W-1:0];
    assign sid = s_tuser[sp_stack_pkg::USER_IN_W-1:sp_stack_pkg::CMD_W];

    // classify
    always_comb begin
        in_item.value = s_tdata;
        in_item.stk   = sp_stack_pkg::STK_W'(sid);
        if (int'(sid) >= sp_stack_pkg::STACK_COUNT) begin
            in_item.kind = sp_stack_pkg::KIND_IGNORE;
        end else if (cmd == sp_stack_pkg::CMD_POP) begin
            in_item.kind = sp_stack_pkg::KIND_POP;
        end else begin
            in_item.kind = sp_stack_pkg::KIND_PUSH;
        end
    end

    assign s_tready  = (count_reg != CNT_W'(sp_stack_pkg::QUEUE_DEPTH));
    assign push_beat = s_tvalid && s_tready;
    assign q_valid   = (count_reg != '0);
    assign pop_beat  = q_pop && q_valid;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_beat) begin
            wr_ptr_next = (int'(wr_ptr_reg) == sp_stack_pkg::QUEUE_DEPTH - 1) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_beat) begin
            rd_ptr_next = (int'(rd_ptr_reg) == sp_stack_pkg::QUEUE_DEPTH - 1) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_beat && !pop_beat) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_beat && !push_beat) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_beat) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/sp_back.sv =====
// ============================================================================
// sp_back: stack execution unit
// Holds tops, links and the occupancy map, reads slot values from RAM,
// carries out one push or pop and registers the result beat.
// ============================================================================
`default_nettype none

module sp_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  q_valid,
    input  wire sp_stack_pkg::item_t                   q_item,
    output logic                                       q_pop,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic        [sp_stack_pkg::VALUE_W-1:0]    m_tdata,
    output logic        [sp_stack_pkg::STATUS_W-1:0]   m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam int IW = sp_stack_pkg::IDX_W;
    localparam int LW = sp_stack_pkg::LINK_W;
    localparam int NS = sp_stack_pkg::POOL_SLOTS;

    state_t                            state_reg, state_next;
    sp_stack_pkg::item_t               cur_reg, cur_next;
    logic [LW-1:0]                     tops_reg  [sp_stack_pkg::STACK_COUNT];
    logic [LW-1:0]                     tops_next [sp_stack_pkg::STACK_COUNT];
    logic [LW-1:0]                     links_reg  [NS];
    logic [LW-1:0]                     links_next [NS];
    logic [NS-1:0]                     used_reg, used_next;
    logic                              out_valid_reg, out_valid_next;
    logic [sp_stack_pkg::VALUE_W-1:0]  out_data_reg, out_data_next;
    sp_stack_pkg::status_t             out_status_reg, out_status_next;

    logic                              out_free;
    logic [IW-1:0]                     head_idx;
    logic [LW-1:0]                     top;
    logic                              top_ok;
    logic [IW-1:0]                     top_idx;
    logic [NS-1:0]                     match_vec;
    sp_stack_pkg::enc_t                free_enc;
    sp_stack_pkg::enc_t                pred_enc;
    logic                              ram_we;
    logic [sp_stack_pkg::VALUE_W-1:0]  ram_rdata;

    assign out_free = !out_valid_reg || m_tready;
    assign head_idx = tops_reg[q_item.stk][IW-1:0];
    assign top      = tops_reg[cur_reg.stk];
    assign top_ok   = (top != sp_stack_pkg::NULL_CODE);
    assign top_idx  = top[IW-1:0];

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            match_vec[s] = (links_reg[s] == top);
        end
    end

    assign free_enc = sp_stack_pkg::lowest_set(~used_reg);
    assign pred_enc = sp_stack_pkg::lowest_set(match_vec);

    assign ram_we = (state_reg == ST_EXEC) && (cur_reg.kind == sp_stack_pkg::KIND_PUSH)
                    && free_enc.found;

    sp_ram #(
        .WIDTH (sp_stack_pkg::VALUE_W),
        .DEPTH (NS)
    ) u_values (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (free_enc.idx),
        .wr_data (cur_reg.value),
        .rd_addr (head_idx),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        tops_next       = tops_reg;
        links_next      = links_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_status_next = sp_stack_pkg::STATUS_OK;
                state_next      = ST_IDLE;
                case (cur_reg.kind)
                    sp_stack_pkg::KIND_PUSH: begin
                        if (!free_enc.found) begin
                            out_status_next = sp_stack_pkg::STATUS_FULL;
                        end else begin
                            links_next[free_enc.idx] = sp_stack_pkg::NULL_CODE;
                            if (top_ok) begin
                                links_next[top_idx] = LW'(free_enc.idx);
                            end
                            tops_next[cur_reg.stk] = LW'(free_enc.idx);
                            used_next[free_enc.idx] = 1'b1;
                        end
                    end
                    sp_stack_pkg::KIND_POP: begin
                        if (!top_ok) begin
                            out_status_next = sp_stack_pkg::STATUS_EMPTY;
                        end else begin
                            out_data_next = ram_rdata;
                            if (pred_enc.found) begin
                                tops_next[cur_reg.stk]   = LW'(pred_enc.idx);
                                links_next[pred_enc.idx] = sp_stack_pkg::NULL_CODE;
                            end else begin
                                tops_next[cur_reg.stk] = sp_stack_pkg::NULL_CODE;
                            end
                            links_next[top_idx] = sp_stack_pkg::NULL_CODE;
                            used_next[top_idx]  = 1'b0;
                        end
                    end
                    default: begin
                        out_status_next = sp_stack_pkg::STATUS_OK;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sp_stack_pkg::STACK_COUNT; i++) begin
                tops_reg[i] <= sp_stack_pkg::NULL_CODE;
            end
            for (int s = 0; s < NS; s++) begin
                links_reg[s] <= sp_stack_pkg::NULL_CODE;
            end
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            tops_reg      <= tops_next;
            links_reg     <= links_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== src/shared_pool_multi_stack_core.sv =====
// ============================================================================
// shared_pool_multi_stack_core: several LIFO stacks in one shared slot pool
// Top level joining the input queue front end and the stack execution unit.
// ============================================================================
// Each input beat is a push or a pop on one of the stacks and gives exactly
// one result beat: the popped value (zero otherwise) and a status of ok, pop
// of an empty stack, or push with the pool full. Beats to a stack id beyond
// the configured count return ok with no state change. The front end queues
// up to two beats, so input stays open while the execution unit works or a
// result waits. For each beat the execution unit first issues, in its idle
// state, the slot value RAM read at the stack's top; its exec state then
// picks the lowest free slot and the predecessor link in parallel and commits
// the update. Results leave through a single output register.
`default_nettype none

module shared_pool_multi_stack_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // push_value
    input  wire logic [sp_stack_pkg::VALUE_W-1:0]     s_tdata,
    // command, stack_id
    input  wire logic [sp_stack_pkg::USER_IN_W-1:0]   s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // pop_value
    output logic      [sp_stack_pkg::VALUE_W-1:0]     m_tdata,
    // status
    output logic      [sp_stack_pkg::STATUS_W-1:0]    m_tuser
);

    logic                 q_valid;
    logic                 q_pop;
    sp_stack_pkg::item_t  q_item;

    sp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
